// ----- src/ksie_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksie_pkg
// Shared codes and constants of the keyed sequence index engine.
// ----------------------------------------------------------------------------
package ksie_pkg;

  localparam logic [2:0] FUNC_INSERT = 3'd0;
  localparam logic [2:0] FUNC_LOOKUP = 3'd1;
  localparam logic [2:0] FUNC_UPDATE = 3'd2;
  localparam logic [2:0] FUNC_DELETE = 3'd3;
  localparam logic [2:0] FUNC_INVAL  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_DIR_FULL  = 2'd2;
  localparam logic [1:0] ST_CAP_ERR   = 2'd3;

  localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
  localparam logic [31:0] FNV_PRIME = 32'h01000193;

  // key bytes, little endian: rel_id, attr_num, group_low, group_high
  localparam int unsigned KEY_BYTES = 22;
  localparam int unsigned KEY_W     = 8 * KEY_BYTES;
  // entry word: offset over cache bits
  localparam int unsigned ENT_W     = 40;

endpackage

// ----- src/ksie_hash.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksie_hash
// Byte-serial FNV-1a over the key, then a remainder by DIR_SLOTS through a
// reciprocal multiply.
// ----------------------------------------------------------------------------
module ksie_hash import ksie_pkg::*; #(
  parameter int unsigned DIR_SLOTS = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [KEY_W-1:0]       key_i,
  output logic                   done_o,
  output logic [(DIR_SLOTS > 1 ? $clog2(DIR_SLOTS) : 1)-1:0] home_o
);

  localparam int unsigned IDX_W = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1;
  // floor(h / DIR_SLOTS) == (h * RECIP) >> SH_W for every 32-bit h
  localparam int unsigned SH_W  = 32 + ((DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 0);
  localparam logic [32:0] RECIP = 33'(((64'd1 << SH_W) / 64'(DIR_SLOTS)) + 64'd1);

  typedef enum logic [1:0] {H_IDLE, H_MIX, H_MUL, H_RED} hst_e;

  hst_e             hst_q;
  logic [4:0]       cnt_q;
  logic [31:0]      h_q;
  logic [64:0]      prod_q;
  logic [IDX_W-1:0] r_q;
  logic             done_q;

  logic [7:0]       byte_b;
  logic [31:0]      mixed;
  logic [31:0]      h_mul;
  logic [31:0]      quo;
  logic [31:0]      rem;

  assign byte_b = key_i[{cnt_q, 3'b000} +: 8];
  assign mixed  = h_q ^ {24'h0, byte_b};
  assign h_mul  = mixed * FNV_PRIME;
  assign quo    = 32'(prod_q >> SH_W);
  assign rem    = h_q - (quo * 32'(DIR_SLOTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hst_q  <= H_IDLE;
      cnt_q  <= '0;
      h_q    <= '0;
      prod_q <= '0;
      r_q    <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (hst_q)
        H_IDLE: begin
          if (start_i) begin
            h_q   <= FNV_BASIS;
            cnt_q <= '0;
            hst_q <= H_MIX;
          end
        end
        H_MIX: begin
          h_q <= h_mul;
          if (cnt_q == 5'(KEY_BYTES - 1)) begin
            hst_q <= H_MUL;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        H_MUL: begin
          prod_q <= 65'(h_q) * 65'(RECIP);
          hst_q  <= H_RED;
        end
        H_RED: begin
          r_q    <= rem[IDX_W-1:0];
          done_q <= 1'b1;
          hst_q  <= H_IDLE;
        end
        default: hst_q <= H_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign home_o = r_q;

endmodule

// ----- src/keyed_sequence_index_engine_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_sequence_index_engine_core
// Hashed key directory with per-group sequence-indexed entry arrays.
// ----------------------------------------------------------------------------
// One request is worked at a time and gives exactly one result. The key is
// hashed one byte per cycle and reduced to a home slot by a reciprocal
// multiply; each directory probe then reads the slot memory, up to DIR_SLOTS
// probes. Insert zero-fills gap entries one per cycle, or, when the window
// grows downward, moves entries up and zero-fills the prepended ones one per
// cycle, all on the single entry memory write port.
// Invalidate sweeps the whole directory, reading each slot, and skips the
// hash. A finished result waits in the output register while the next
// request is taken.
module keyed_sequence_index_engine_core import ksie_pkg::*; #(
  parameter int unsigned DIR_SLOTS = 256,
  parameter int unsigned GROUP_CAP = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         func_i,
  input  logic [31:0]        rel_id_i,
  input  logic signed [15:0] attr_num_i,
  input  logic [63:0]        group_low_i,
  input  logic [63:0]        group_high_i,
  input  logic signed [63:0] seq_num_i,
  input  logic [31:0]        offset_in_i,
  input  logic [7:0]         bits_in_i,
  input  logic [7:0]         set_mask_i,
  input  logic [7:0]         clear_mask_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [31:0]        offset_out_o,
  output logic [7:0]         bits_out_o
);

  localparam int unsigned IDX_W     = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1;
  localparam int unsigned CNT_W     = $clog2(GROUP_CAP + 1);
  localparam int unsigned ENT_DEPTH = DIR_SLOTS * GROUP_CAP;
  localparam int unsigned EA_W      = $clog2(ENT_DEPTH);

  typedef struct packed {
    logic [31:0]      rel;
    logic [15:0]      attr;
    logic [63:0]      lo;
    logic [63:0]      hi;
    logic [63:0]      base;
    logic [63:0]      last;
    logic [CNT_W-1:0] cnt;
  } rec_t;

  typedef enum logic [3:0] {
    S_IDLE, S_HASH, S_PRD, S_PEV, S_ADDR, S_OP, S_FILL, S_SHIFT,
    S_ZERO, S_EWAIT, S_EEV, S_INV, S_INVE, S_DONE
  } st_e;

  st_e              state_q;
  logic [2:0]       func_q;
  logic [31:0]      rel_q;
  logic [15:0]      attr_q;
  logic [63:0]      lo_q, hi_q, seq_q;
  logic [31:0]      off_q;
  logic [7:0]       bits_q, setm_q, clrm_q;

  logic             hash_start_q;
  logic             hash_done;
  logic [IDX_W-1:0] home;

  logic [DIR_SLOTS-1:0] used_q, tomb_q;
  logic [IDX_W-1:0] idx_q, probe_n_q, tomb_idx_q, slot_q;
  logic             tomb_hit_q, fresh_q, pend_q;
  rec_t             rec_q;
  logic [EA_W-1:0]  ea_base_q;
  logic [CNT_W-1:0] j_q, pj_q, k_q, end_q, ofs_q;

  logic [1:0]       res_status_q;
  logic [31:0]      res_off_q;
  logic [7:0]       res_bits_q;
  logic             out_valid_q;
  logic [1:0]       status_q;
  logic [31:0]      offset_q;
  logic [7:0]       bits_out_q;

  // memories
  rec_t             slot_mem [DIR_SLOTS];
  rec_t             slot_rd_q;
  logic             slot_we_q;
  logic [IDX_W-1:0] slot_wa_q;
  rec_t             slot_wd_q;

  logic [ENT_W-1:0] ent_mem [ENT_DEPTH];
  logic [ENT_W-1:0] ent_rd_q;
  logic             ent_we_q;
  logic [EA_W-1:0]  ent_wa_q;
  logic [ENT_W-1:0] ent_wd_q;
  logic [EA_W-1:0]  ent_ra;

  ksie_hash #(.DIR_SLOTS(DIR_SLOTS)) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start_q),
    .key_i   ({hi_q, lo_q, attr_q, rel_q}),
    .done_o  (hash_done),
    .home_o  (home)
  );

  always_ff @(posedge clk_i) begin
    if (slot_we_q) begin
      slot_mem[slot_wa_q] <= slot_wd_q;
    end
    slot_rd_q <= slot_mem[idx_q];
  end

  assign ent_ra = ea_base_q + ((state_q == S_SHIFT) ? (EA_W'(j_q) - EA_W'(1))
                                                    : EA_W'(ofs_q));

  always_ff @(posedge clk_i) begin
    if (ent_we_q) begin
      ent_mem[ent_wa_q] <= ent_wd_q;
    end
    ent_rd_q <= ent_mem[ent_ra];
  end

  // probe evaluation
  logic             cur_used, cur_tomb, key_eq, last_probe, tomb_any;
  logic [IDX_W-1:0] tomb_pick, next_idx;
  rec_t             new_rec;

  assign cur_used   = used_q[idx_q];
  assign cur_tomb   = tomb_q[idx_q];
  assign key_eq     = (slot_rd_q.rel == rel_q) && (slot_rd_q.attr == attr_q) &&
                      (slot_rd_q.lo == lo_q) && (slot_rd_q.hi == hi_q);
  assign last_probe = (probe_n_q == IDX_W'(DIR_SLOTS - 1));
  assign next_idx   = (idx_q == IDX_W'(DIR_SLOTS - 1)) ? '0 : idx_q + IDX_W'(1);
  assign tomb_any   = tomb_hit_q | cur_tomb;
  assign tomb_pick  = tomb_hit_q ? tomb_idx_q : idx_q;
  assign new_rec    = '{rel: rel_q, attr: attr_q, lo: lo_q, hi: hi_q,
                        base: seq_q, last: seq_q, cnt: CNT_W'(1)};

  // window arithmetic
  logic [63:0]      d, sh;
  logic             seq_gt_last, seq_lt_base, d_lt_cap, pre_fits, in_win;
  logic [CNT_W-1:0] d_ofs, sh_ofs;

  assign d           = seq_q - rec_q.base;
  assign sh          = rec_q.base - seq_q;
  assign seq_gt_last = $signed(seq_q) > $signed(rec_q.last);
  assign seq_lt_base = $signed(seq_q) < $signed(rec_q.base);
  assign d_lt_cap    = d < 64'(GROUP_CAP);
  assign d_ofs       = d[CNT_W-1:0];
  assign sh_ofs      = sh[CNT_W-1:0];
  assign pre_fits    = (sh < 64'(GROUP_CAP)) &&
                       (({1'b0, rec_q.cnt} + {1'b0, sh_ofs}) <= (CNT_W + 1)'(GROUP_CAP));
  assign in_win      = (rec_q.cnt != '0) && !seq_lt_base && !seq_gt_last &&
                       (d < 64'(rec_q.cnt));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      func_q       <= '0;
      rel_q        <= '0;
      attr_q       <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      seq_q        <= '0;
      off_q        <= '0;
      bits_q       <= '0;
      setm_q       <= '0;
      clrm_q       <= '0;
      hash_start_q <= 1'b0;
      used_q       <= '0;
      tomb_q       <= '0;
      idx_q        <= '0;
      probe_n_q    <= '0;
      tomb_idx_q   <= '0;
      slot_q       <= '0;
      tomb_hit_q   <= 1'b0;
      fresh_q      <= 1'b0;
      pend_q       <= 1'b0;
      rec_q        <= '0;
      ea_base_q    <= '0;
      j_q          <= '0;
      pj_q         <= '0;
      k_q          <= '0;
      end_q        <= '0;
      ofs_q        <= '0;
      res_status_q <= ST_OK;
      res_off_q    <= '0;
      res_bits_q   <= '0;
      out_valid_q  <= 1'b0;
      status_q     <= ST_OK;
      offset_q     <= '0;
      bits_out_q   <= '0;
      slot_we_q    <= 1'b0;
      slot_wa_q    <= '0;
      slot_wd_q    <= '0;
      ent_we_q     <= 1'b0;
      ent_wa_q     <= '0;
      ent_wd_q     <= '0;
    end else begin
      hash_start_q <= 1'b0;
      slot_we_q    <= 1'b0;
      ent_we_q     <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            func_q     <= func_i;
            rel_q      <= rel_id_i;
            attr_q     <= attr_num_i;
            lo_q       <= group_low_i;
            hi_q       <= group_high_i;
            seq_q      <= seq_num_i;
            off_q      <= offset_in_i;
            bits_q     <= bits_in_i;
            setm_q     <= set_mask_i;
            clrm_q     <= clear_mask_i;
            fresh_q    <= 1'b0;
            res_off_q  <= '0;
            res_bits_q <= '0;
            if (func_i == FUNC_INVAL) begin
              idx_q   <= '0;
              state_q <= S_INV;
            end else if (func_i > FUNC_INVAL) begin
              res_status_q <= ST_NOT_FOUND;
              state_q      <= S_DONE;
            end else begin
              hash_start_q <= 1'b1;
              state_q      <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            idx_q      <= home;
            probe_n_q  <= '0;
            tomb_hit_q <= 1'b0;
            state_q    <= S_PRD;
          end
        end
        S_PRD: state_q <= S_PEV;
        S_PEV: begin
          if (cur_used && key_eq) begin
            slot_q  <= idx_q;
            rec_q   <= slot_rd_q;
            state_q <= S_ADDR;
          end else if ((!cur_used && !cur_tomb) || last_probe) begin
            if (func_q == FUNC_INSERT && ((!cur_used && !cur_tomb) || tomb_any)) begin
              // new group takes the first tombstone passed, else this empty slot
              slot_we_q         <= 1'b1;
              slot_wa_q         <= tomb_pick;
              slot_wd_q         <= new_rec;
              used_q[tomb_pick] <= 1'b1;
              tomb_q[tomb_pick] <= 1'b0;
              slot_q            <= tomb_pick;
              rec_q             <= new_rec;
              fresh_q           <= 1'b1;
              state_q           <= S_ADDR;
            end else begin
              res_status_q <= (func_q == FUNC_INSERT) ? ST_DIR_FULL : ST_NOT_FOUND;
              state_q      <= S_DONE;
            end
          end else begin
            if (cur_tomb && !tomb_hit_q) begin
              tomb_hit_q <= 1'b1;
              tomb_idx_q <= idx_q;
            end
            idx_q     <= next_idx;
            probe_n_q <= probe_n_q + IDX_W'(1);
            state_q   <= S_PRD;
          end
        end
        S_ADDR: begin
          ea_base_q <= EA_W'(slot_q) * EA_W'(GROUP_CAP);
          state_q   <= S_OP;
        end
        S_OP: begin
          res_status_q <= ST_OK;
          state_q      <= S_DONE;
          case (func_q)
            FUNC_INSERT: begin
              if (fresh_q || rec_q.cnt == '0) begin
                slot_we_q <= 1'b1;
                slot_wa_q <= slot_q;
                slot_wd_q <= new_rec;
                ent_we_q  <= 1'b1;
                ent_wa_q  <= ea_base_q;
                ent_wd_q  <= {off_q, bits_q};
              end else if (seq_gt_last) begin
                if (!d_lt_cap) begin
                  res_status_q <= ST_CAP_ERR;
                end else begin
                  slot_we_q      <= 1'b1;
                  slot_wa_q      <= slot_q;
                  slot_wd_q      <= rec_q;
                  slot_wd_q.cnt  <= d_ofs + CNT_W'(1);
                  slot_wd_q.last <= seq_q;
                  j_q            <= rec_q.cnt;
                  end_q          <= d_ofs;
                  state_q        <= S_FILL;
                end
              end else if (seq_lt_base) begin
                if (!pre_fits) begin
                  res_status_q <= ST_CAP_ERR;
                end else begin
                  slot_we_q      <= 1'b1;
                  slot_wa_q      <= slot_q;
                  slot_wd_q      <= rec_q;
                  slot_wd_q.cnt  <= rec_q.cnt + sh_ofs;
                  slot_wd_q.base <= seq_q;
                  k_q            <= sh_ofs;
                  j_q            <= rec_q.cnt;
                  pend_q         <= 1'b0;
                  state_q        <= S_SHIFT;
                end
              end else begin
                ent_we_q <= 1'b1;
                ent_wa_q <= ea_base_q + EA_W'(d_ofs);
                ent_wd_q <= {off_q, bits_q};
              end
            end
            FUNC_LOOKUP, FUNC_UPDATE: begin
              if (in_win) begin
                ofs_q   <= d_ofs;
                state_q <= S_EWAIT;
              end else begin
                res_status_q <= ST_NOT_FOUND;
              end
            end
            FUNC_DELETE: begin
              if (rec_q.cnt == '0) begin
                res_status_q <= ST_NOT_FOUND;
              end else if (seq_lt_base || d == 64'd0) begin
                used_q[slot_q] <= 1'b0;
                tomb_q[slot_q] <= 1'b1;
              end else if (d < 64'(rec_q.cnt)) begin
                slot_we_q      <= 1'b1;
                slot_wa_q      <= slot_q;
                slot_wd_q      <= rec_q;
                slot_wd_q.cnt  <= d_ofs;
                slot_wd_q.last <= seq_q - 64'd1;
              end
            end
            default: res_status_q <= ST_NOT_FOUND;
          endcase
        end
        S_FILL: begin
          ent_we_q <= 1'b1;
          ent_wa_q <= ea_base_q + EA_W'(j_q);
          if (j_q == end_q) begin
            ent_wd_q     <= {off_q, bits_q};
            res_status_q <= ST_OK;
            state_q      <= S_DONE;
          end else begin
            ent_wd_q <= '0;
            j_q      <= j_q + CNT_W'(1);
          end
        end
        S_SHIFT: begin
          // read entry j-1 while writing the one read last cycle k places up
          if (pend_q) begin
            ent_we_q <= 1'b1;
            ent_wa_q <= ea_base_q + EA_W'(pj_q) + EA_W'(k_q);
            ent_wd_q <= ent_rd_q;
          end
          if (j_q != '0) begin
            pj_q   <= j_q - CNT_W'(1);
            j_q    <= j_q - CNT_W'(1);
            pend_q <= 1'b1;
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              state_q <= S_ZERO;
            end
          end
        end
        S_ZERO: begin
          ent_we_q <= 1'b1;
          ent_wa_q <= ea_base_q + EA_W'(j_q);
          ent_wd_q <= (j_q == '0) ? {off_q, bits_q} : '0;
          if (j_q == k_q - CNT_W'(1)) begin
            res_status_q <= ST_OK;
            state_q      <= S_DONE;
          end else begin
            j_q <= j_q + CNT_W'(1);
          end
        end
        S_EWAIT: state_q <= S_EEV;
        S_EEV: begin
          state_q <= S_DONE;
          if (ent_rd_q != '0) begin
            res_status_q <= ST_OK;
            if (func_q == FUNC_LOOKUP) begin
              res_off_q  <= ent_rd_q[ENT_W-1:8];
              res_bits_q <= ent_rd_q[7:0];
            end else begin
              ent_we_q <= 1'b1;
              ent_wa_q <= ea_base_q + EA_W'(ofs_q);
              ent_wd_q <= {ent_rd_q[ENT_W-1:8], (ent_rd_q[7:0] | setm_q) & ~clrm_q};
            end
          end else begin
            res_status_q <= ST_NOT_FOUND;
          end
        end
        S_INV: state_q <= S_INVE;
        S_INVE: begin
          if (used_q[idx_q] && slot_rd_q.rel == rel_q) begin
            used_q[idx_q] <= 1'b0;
            tomb_q[idx_q] <= 1'b1;
          end
          if (idx_q == IDX_W'(DIR_SLOTS - 1)) begin
            res_status_q <= ST_OK;
            state_q      <= S_DONE;
          end else begin
            idx_q   <= idx_q + IDX_W'(1);
            state_q <= S_INV;
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            status_q    <= res_status_q;
            offset_q    <= res_off_q;
            bits_out_q  <= res_bits_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign offset_out_o = offset_q;
  assign bits_out_o   = bits_out_q;

endmodule

// ----- bench/ksie_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksie_checker
// Watches both channels of the index engine, predicts every result from its
// own copy of the directory and entry arrays, and compares field by field.
// ----------------------------------------------------------------------------
module ksie_checker import ksie_pkg::*; #(
  parameter int unsigned DIR_SLOTS = 256,
  parameter int unsigned GROUP_CAP = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         func_i,
  input  logic [31:0]        rel_id_i,
  input  logic signed [15:0] attr_num_i,
  input  logic [63:0]        group_low_i,
  input  logic [63:0]        group_high_i,
  input  logic signed [63:0] seq_num_i,
  input  logic [31:0]        offset_in_i,
  input  logic [7:0]         bits_in_i,
  input  logic [7:0]         set_mask_i,
  input  logic [7:0]         clear_mask_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         status_i,
  input  logic [31:0]        offset_out_i,
  input  logic [7:0]         bits_out_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 results_seen_o
);

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] offset;
    logic [7:0]  bits;
  } result_t;

  result_t     expected_results[$];

  bit          used[DIR_SLOTS];
  bit          tomb[DIR_SLOTS];
  logic [31:0] s_rel[DIR_SLOTS];
  logic [15:0] s_attr[DIR_SLOTS];
  logic [63:0] s_lo[DIR_SLOTS];
  logic [63:0] s_hi[DIR_SLOTS];
  logic [63:0] s_base[DIR_SLOTS];
  logic [63:0] s_max[DIR_SLOTS];
  int unsigned s_cnt[DIR_SLOTS];
  logic [31:0] e_off[DIR_SLOTS*GROUP_CAP];
  logic [7:0]  e_bits[DIR_SLOTS*GROUP_CAP];

  int fails = 0;
  int seen = 0;
  assign fail_count_o   = fails;
  assign pending_o      = expected_results.size();
  assign results_seen_o = seen;

  function automatic logic [31:0] fnv_key(logic [31:0] rel, logic [15:0] attr,
                                          logic [63:0] lo, logic [63:0] hi);
    logic [175:0] k;
    logic [31:0]  h;
    k = {hi, lo, attr, rel};
    h = FNV_BASIS;
    for (int i = 0; i < 22; i++) h = (h ^ {24'd0, k[8*i +: 8]}) * FNV_PRIME;
    return h;
  endfunction

  function automatic bit key_hit(int s, logic [31:0] rel, logic [15:0] attr,
                                 logic [63:0] lo, logic [63:0] hi);
    return used[s] && s_rel[s] == rel && s_attr[s] == attr && s_lo[s] == lo &&
           s_hi[s] == hi;
  endfunction

  function automatic int probe_slot(logic [31:0] rel, logic [15:0] attr,
                                    logic [63:0] lo, logic [63:0] hi);
    int idx;
    idx = fnv_key(rel, attr, lo, hi) % DIR_SLOTS;
    for (int n = 0; n < DIR_SLOTS; n++) begin
      if (!used[idx] && !tomb[idx]) return DIR_SLOTS;
      if (key_hit(idx, rel, attr, lo, hi)) return idx;
      idx = (idx + 1) % DIR_SLOTS;
    end
    return DIR_SLOTS;
  endfunction

  function automatic int claim_slot(logic [31:0] rel, logic [15:0] attr,
                                    logic [63:0] lo, logic [63:0] hi, output bit fresh);
    int idx, first_tomb, pick;
    idx = fnv_key(rel, attr, lo, hi) % DIR_SLOTS;
    first_tomb = DIR_SLOTS;
    pick = DIR_SLOTS;
    fresh = 0;
    for (int n = 0; n < DIR_SLOTS; n++) begin
      if (!used[idx] && !tomb[idx]) begin
        pick = (first_tomb != DIR_SLOTS) ? first_tomb : idx;
        break;
      end
      if (tomb[idx] && first_tomb == DIR_SLOTS) first_tomb = idx;
      if (key_hit(idx, rel, attr, lo, hi)) return idx;
      idx = (idx + 1) % DIR_SLOTS;
    end
    if (pick == DIR_SLOTS) pick = first_tomb;
    if (pick == DIR_SLOTS) return DIR_SLOTS;
    used[pick] = 1;
    tomb[pick] = 0;
    s_rel[pick] = rel;
    s_attr[pick] = attr;
    s_lo[pick] = lo;
    s_hi[pick] = hi;
    s_base[pick] = 0;
    s_max[pick] = 0;
    s_cnt[pick] = 0;
    fresh = 1;
    return pick;
  endfunction

  function automatic int win_index(int s, logic [63:0] seq);
    logic [63:0] d;
    if (s_cnt[s] == 0 || $signed(seq) < $signed(s_base[s]) ||
        $signed(s_max[s]) < $signed(seq)) return GROUP_CAP;
    d = seq - s_base[s];
    if (d >= s_cnt[s]) return GROUP_CAP;
    return int'(d);
  endfunction

  function automatic void bury_slot(int s);
    for (int i = 0; i < GROUP_CAP; i++) begin
      e_off[s*GROUP_CAP+i] = 0;
      e_bits[s*GROUP_CAP+i] = 0;
    end
    used[s] = 0;
    tomb[s] = 1;
    s_cnt[s] = 0;
    s_base[s] = 0;
    s_max[s] = 0;
  endfunction

  function automatic logic [1:0] insert_entry(int s, bit fresh, logic [63:0] seq,
                                              logic [31:0] off, logic [7:0] bits);
    int b, cnt, k, i;
    logic [63:0] d;
    b = s * GROUP_CAP;
    cnt = s_cnt[s];
    if (fresh || cnt == 0) begin
      s_base[s] = seq;
      s_max[s] = seq;
      s_cnt[s] = 1;
    end else if ($signed(s_max[s]) < $signed(seq)) begin
      d = seq - s_base[s];
      if (d >= GROUP_CAP) return ST_CAP_ERR;
      for (i = cnt; i <= int'(d); i++) begin
        e_off[b+i] = 0;
        e_bits[b+i] = 0;
      end
      s_cnt[s] = int'(d) + 1;
      s_max[s] = seq;
    end else if ($signed(seq) < $signed(s_base[s])) begin
      d = s_base[s] - seq;
      if (d >= GROUP_CAP || cnt + d > GROUP_CAP) return ST_CAP_ERR;
      k = int'(d);
      for (i = cnt; i > 0; i--) begin
        e_off[b+i-1+k] = e_off[b+i-1];
        e_bits[b+i-1+k] = e_bits[b+i-1];
      end
      for (i = 0; i < k; i++) begin
        e_off[b+i] = 0;
        e_bits[b+i] = 0;
      end
      s_cnt[s] = cnt + k;
      s_base[s] = seq;
    end
    i = win_index(s, seq);
    if (i < GROUP_CAP) begin
      e_off[b+i] = off;
      e_bits[b+i] = bits;
    end
    return ST_OK;
  endfunction

  function automatic logic [1:0] truncate_group(int s, logic [63:0] seq);
    int b, cnt;
    logic [63:0] start;
    b = s * GROUP_CAP;
    cnt = s_cnt[s];
    if (cnt == 0) return ST_NOT_FOUND;
    start = ($signed(seq) < $signed(s_base[s])) ? 64'd0 : seq - s_base[s];
    if (start >= cnt) return ST_OK;
    for (int i = int'(start); i < cnt; i++) begin
      e_off[b+i] = 0;
      e_bits[b+i] = 0;
    end
    if (start == 0) bury_slot(s);
    else begin
      s_max[s] = seq - 64'd1;
      s_cnt[s] = int'(start);
    end
    return ST_OK;
  endfunction

  function automatic result_t predict_request();
    result_t r;
    int s, i, e;
    bit fresh;
    r = '{status: ST_NOT_FOUND, offset: 32'd0, bits: 8'd0};
    case (func_i)
      FUNC_INSERT: begin
        s = claim_slot(rel_id_i, attr_num_i, group_low_i, group_high_i, fresh);
        r.status = (s == DIR_SLOTS) ? ST_DIR_FULL :
                   insert_entry(s, fresh, seq_num_i, offset_in_i, bits_in_i);
      end
      FUNC_LOOKUP, FUNC_UPDATE: begin
        s = probe_slot(rel_id_i, attr_num_i, group_low_i, group_high_i);
        if (s != DIR_SLOTS) begin
          i = win_index(s, seq_num_i);
          if (i < GROUP_CAP) begin
            e = s * GROUP_CAP + i;
            if (e_off[e] != 0 || e_bits[e] != 0) begin
              r.status = ST_OK;
              if (func_i == FUNC_LOOKUP) begin
                r.offset = e_off[e];
                r.bits = e_bits[e];
              end else e_bits[e] = (e_bits[e] | set_mask_i) & ~clear_mask_i;
            end
          end
        end
      end
      FUNC_DELETE: begin
        s = probe_slot(rel_id_i, attr_num_i, group_low_i, group_high_i);
        if (s != DIR_SLOTS) r.status = truncate_group(s, seq_num_i);
      end
      FUNC_INVAL: begin
        for (s = 0; s < DIR_SLOTS; s++)
          if (used[s] && s_rel[s] == rel_id_i) bury_slot(s);
        r.status = ST_OK;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      expected_results.delete();
      for (int s = 0; s < DIR_SLOTS; s++) begin
        used[s] = 0;
        tomb[s] = 0;
        s_cnt[s] = 0;
      end
    end else begin
      if (out_valid_i && !out_stall_i) begin
        seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 32'(status_i), 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (status_i !== want.status)
            report_mismatch("status", 32'(status_i), 32'(want.status));
          if (offset_out_i !== want.offset)
            report_mismatch("offset", offset_out_i, want.offset);
          if (bits_out_i !== want.bits)
            report_mismatch("bits", 32'(bits_out_i), 32'(want.bits));
        end
      end
      if (in_valid_i && !in_stall_i) expected_results.push_back(predict_request());
    end
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random requests into the index engine with bursty
// sender gaps and receiver stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import ksie_pkg::*;

  // function codes with no operation behind them
  localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
  localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic [2:0]         func = 0;
  logic [31:0]        rel_id = 0;
  logic signed [15:0] attr_num = 0;
  logic [63:0]        group_low = 0;
  logic [63:0]        group_high = 0;
  logic signed [63:0] seq_num = 0;
  logic [31:0]        offset_in = 0;
  logic [7:0]         bits_in = 0;
  logic [7:0]         set_mask = 0;
  logic [7:0]         clear_mask = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [1:0]         status;
  logic [31:0]        offset_out;
  logic [7:0]         bits_out;
  int                 fail_count, pending, results_seen;
  int                 idle_cycles = 0;
  int                 sent = 0;
  bit                 timed_out = 0;
  bit                 finished = 0;

  typedef struct {
    logic [2:0]  func;
    logic [31:0] rel;
    logic [15:0] attr;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] seq;
    logic [31:0] off;
    logic [7:0]  bits;
    logic [7:0]  setm;
    logic [7:0]  clrm;
  } request_t;

  // small pool of keys so groups get revisited
  logic [31:0] pool_rel[8];
  logic [15:0] pool_attr[8];
  logic [63:0] pool_lo[8];
  logic [63:0] pool_hi[8];

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  keyed_sequence_index_engine_core dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .func_i(func), .rel_id_i(rel_id), .attr_num_i(attr_num), .group_low_i(group_low),
    .group_high_i(group_high), .seq_num_i(seq_num), .offset_in_i(offset_in),
    .bits_in_i(bits_in), .set_mask_i(set_mask), .clear_mask_i(clear_mask),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .status_o(status),
    .offset_out_o(offset_out), .bits_out_o(bits_out)
  );

  ksie_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .func_i(func), .rel_id_i(rel_id), .attr_num_i(attr_num), .group_low_i(group_low),
    .group_high_i(group_high), .seq_num_i(seq_num), .offset_in_i(offset_in),
    .bits_in_i(bits_in), .set_mask_i(set_mask), .clear_mask_i(clear_mask),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .status_i(status),
    .offset_out_i(offset_out), .bits_out_i(bits_out), .fail_count_o(fail_count),
    .pending_o(pending), .results_seen_o(results_seen)
  );

  // receiver stall pattern: phases of no stall, light and heavy stalling
  always @(posedge clk) begin
    int mode;
    mode = int'(($time / 4000) % 3);
    if (mode == 0) out_stall <= 0;
    else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= ($urandom_range(0, 2) != 0);
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || finished || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == 20000 && !timed_out) begin
      timed_out = 1;
      $display("keyed_sequence_index_engine_core verification failed");
      $finish;
    end
  end

  task automatic send_request(request_t r);
    func <= r.func;
    rel_id <= r.rel;
    attr_num <= r.attr;
    group_low <= r.lo;
    group_high <= r.hi;
    seq_num <= r.seq;
    offset_in <= r.off;
    bits_in <= r.bits;
    set_mask <= r.setm;
    clear_mask <= r.clrm;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic maybe_gap();
    int gap;
    if ($urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic request_t pool_request(logic [2:0] f, int k, logic [63:0] seq);
    request_t r;
    r.func = f;
    r.rel = pool_rel[k];
    r.attr = pool_attr[k];
    r.lo = pool_lo[k];
    r.hi = pool_hi[k];
    r.seq = seq;
    r.off = $urandom();
    r.bits = 8'($urandom());
    r.setm = 8'($urandom());
    r.clrm = 8'($urandom());
    return r;
  endfunction

  function automatic request_t noise_request();
    request_t r;
    r.func = 3'($urandom_range(0, 7));
    r.rel = $urandom();
    r.attr = 16'($urandom());
    r.lo = {$urandom(), $urandom()};
    r.hi = {$urandom(), $urandom()};
    r.seq = {$urandom(), $urandom()};
    r.off = $urandom();
    r.bits = 8'($urandom());
    r.setm = 8'($urandom());
    r.clrm = 8'($urandom());
    return r;
  endfunction

  initial begin
    request_t r;
    int k;
    logic [63:0] base;
    for (int i = 0; i < 8; i++) begin
      pool_rel[i] = (i < 4) ? 32'd7 : $urandom();
      pool_attr[i] = 16'($urandom());
      pool_lo[i] = {$urandom(), $urandom()};
      pool_hi[i] = {$urandom(), $urandom()};
    end
    pool_rel[7] = '1;
    pool_attr[7] = 16'h8000;
    pool_lo[7] = '1;
    pool_hi[7] = '1;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: create, extend, prepend, capacity, hit/miss, update, delete, invalidate, spare codes
    send_request(pool_request(FUNC_LOOKUP, 0, 64'd5));
    r = pool_request(FUNC_INSERT, 0, 64'd10);
    r.off = '1; r.bits = '1;
    send_request(r);
    send_request(pool_request(FUNC_INSERT, 0, 64'd14));
    send_request(pool_request(FUNC_INSERT, 0, 64'd8));
    send_request(pool_request(FUNC_INSERT, 0, 64'd10 + 64'd70));
    send_request(pool_request(FUNC_INSERT, 0, 64'd8 - 64'd60));
    send_request(pool_request(FUNC_LOOKUP, 0, 64'd10));
    send_request(pool_request(FUNC_LOOKUP, 0, 64'd12));
    send_request(pool_request(FUNC_LOOKUP, 0, 64'd99));
    send_request(pool_request(FUNC_UPDATE, 0, 64'd12));
    r = pool_request(FUNC_UPDATE, 0, 64'd10);
    r.setm = 0; r.clrm = '1;
    send_request(r);
    r = pool_request(FUNC_INSERT, 0, 64'd10);
    r.off = 0; r.bits = 0;
    send_request(r);
    send_request(pool_request(FUNC_LOOKUP, 0, 64'd10));
    send_request(pool_request(FUNC_DELETE, 0, 64'd12));
    send_request(pool_request(FUNC_DELETE, 0, 64'd50));
    send_request(pool_request(FUNC_DELETE, 0, 64'h8000_0000_0000_0000));
    send_request(pool_request(FUNC_DELETE, 0, 64'd1));
    send_request(pool_request(FUNC_INSERT, 7, 64'h7fff_ffff_ffff_ffff));
    send_request(pool_request(FUNC_INSERT, 7, 64'h7fff_ffff_ffff_ffc1));
    send_request(pool_request(FUNC_LOOKUP, 7, 64'h7fff_ffff_ffff_ffff));
    send_request(pool_request(FUNC_INSERT, 1, 64'h8000_0000_0000_0000));
    send_request(pool_request(FUNC_INSERT, 2, 64'd3));
    send_request(pool_request(FUNC_INVAL, 1, 64'd0));
    send_request(pool_request(FUNC_LOOKUP, 2, 64'd3));
    send_request(pool_request(FUNC_SPARE_FIRST, 3, 64'd0));
    send_request(pool_request(FUNC_SPARE_LAST, 3, 64'd0));

    // random: mostly pooled keys near a window, some noise
    while (sent < 380) begin
      k = $urandom_range(0, 7);
      base = {$urandom(), $urandom()};
      if ($urandom_range(0, 9) < 8) begin
        for (int j = 0; j < $urandom_range(3, 10); j++) begin
          r = pool_request($urandom_range(0, 9) < 4 ? FUNC_INSERT :
                           $urandom_range(0, 2) == 0 ? FUNC_UPDATE :
                           $urandom_range(0, 3) == 0 ? FUNC_DELETE : FUNC_LOOKUP,
                           k, 64'd1000 + $urandom_range(0, 80));
          if ($urandom_range(0, 40) == 0) r.func = FUNC_INVAL;
          if ($urandom_range(0, 20) == 0) r.seq = base;
          send_request(r);
          maybe_gap();
        end
      end else begin
        send_request(noise_request());
        maybe_gap();
      end
    end

    // insert past a full directory under one rel_id, then invalidate that rel_id
    for (int i = 0; i < 270; i++) begin
      r = noise_request();
      r.func = FUNC_INSERT;
      r.rel = 32'h5a5a_0001;
      send_request(r);
    end
    r = noise_request();
    r.func = FUNC_INVAL;
    r.rel = 32'h5a5a_0001;
    send_request(r);
    in_valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    finished = 1;
    $display("sent %0d requests, checked %0d results", sent, results_seen);
    $display("covered insert/lookup/update/delete/invalidate, full directory, window growth");
    if (fail_count == 0 && pending == 0) begin
      $display("keyed_sequence_index_engine_core verification clean");
    end else begin
      $display("keyed_sequence_index_engine_core verification failed");
    end
    $finish;
  end

endmodule
